[src/rar_pkg.sv]
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the rational reduce unit
// Operation codes, widths and the request record passed front to back.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int MAG_W         = 2 * OPERAND_WIDTH + 1;
    localparam int OUT_W         = 33;
    localparam int CNT_W         = $clog2(MAG_W + 1);
    localparam int Q_DEPTH       = 2;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    // sign-magnitude raw fraction
    typedef struct packed {
        logic             num_neg;
        logic [MAG_W-1:0] num_mag;
        logic             den_neg;
        logic [MAG_W-1:0] den_mag;
    } t_raw;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } t_state;

endpackage

[src/rar_front.sv]
// ----------------------------------------------------------------------------
// rar_front: operand intake and raw cross products
// Accepts a request, forms the products in two registered steps and
// hands the signed raw fraction on to the queue.
// ----------------------------------------------------------------------------
module rar_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_func,
    input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] i_b_den,
    output logic                              o_valid,
    input  logic                              i_ready,
    output rar_pkg::t_raw                     o_raw
);
    import rar_pkg::*;

    localparam int W = OPERAND_WIDTH;
    localparam int P = 2 * W;

    logic          r_s1_vld, r_s2_vld;
    logic [1:0]    r_func;
    logic          r_p_neg, r_q_neg, r_d_neg;
    logic [P-1:0]  r_p_mag, r_q_mag, r_d_mag;
    t_raw          r_raw;

    logic [W-1:0] an_m, ad_m, bn_m, bd_m;
    logic [W-1:0] x1, y1, x2, y2;
    logic         x1n, y1n, x2n, y2n;
    logic [P-1:0] m1, m2, m3;
    logic [MAG_W-1:0] pe, qe, sum;
    logic         q_neg, sum_neg;

    function automatic logic [W-1:0] fmag(input logic [W-1:0] v);
        fmag = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    assign an_m = fmag(i_a_num);
    assign ad_m = fmag(i_a_den);
    assign bn_m = fmag(i_b_num);
    assign bd_m = fmag(i_b_den);

    // operand pairing per operation
    always_comb begin
        x1 = an_m; x1n = i_a_num[W-1];
        y1 = bd_m; y1n = i_b_den[W-1];
        x2 = bn_m; x2n = i_b_num[W-1];
        y2 = ad_m; y2n = i_a_den[W-1];
        if (t_func'(i_func) == FUNC_MUL) begin
            y1 = bn_m; y1n = i_b_num[W-1];
        end
    end

    assign m1 = P'(x1) * P'(y1);
    assign m2 = P'(x2) * P'(y2);
    assign m3 = (t_func'(i_func) == FUNC_DIV) ? P'(ad_m) * P'(bn_m)
                                              : P'(ad_m) * P'(bd_m);

    logic stall2, adv1;
    assign stall2  = r_s2_vld && !i_ready;
    assign adv1    = !(r_s1_vld && stall2);
    assign o_ready = adv1;

    // stage one: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv1) begin
            r_s1_vld <= i_valid;
        end
        if (adv1 && i_valid) begin
            r_func  <= i_func;
            r_p_mag <= m1;
            r_p_neg <= (m1 != '0) && (x1n != y1n);
            r_q_mag <= m2;
            r_q_neg <= (m2 != '0) && (x2n != y2n) != (t_func'(i_func) == FUNC_SUB);
            r_d_mag <= m3;
            r_d_neg <= (m3 != '0) && (i_a_den[W-1] !=
                ((t_func'(i_func) == FUNC_DIV) ? i_b_num[W-1] : i_b_den[W-1]));
        end
    end

    // stage two: signed add for add and subtract
    assign pe    = MAG_W'(r_p_mag);
    assign qe    = MAG_W'(r_q_mag);
    assign q_neg = (r_q_mag != '0) && r_q_neg;
    always_comb begin
        if (r_p_neg == q_neg) begin
            sum = pe + qe; sum_neg = r_p_neg;
        end else if (pe >= qe) begin
            sum = pe - qe; sum_neg = r_p_neg;
        end else begin
            sum = qe - pe; sum_neg = q_neg;
        end
        if (sum == '0) sum_neg = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (!stall2) begin
            r_s2_vld <= r_s1_vld;
        end
        if (!stall2 && r_s1_vld) begin
            if (t_func'(r_func) == FUNC_ADD || t_func'(r_func) == FUNC_SUB) begin
                r_raw.num_mag <= sum;
                r_raw.num_neg <= sum_neg;
            end else begin
                r_raw.num_mag <= pe;
                r_raw.num_neg <= r_p_neg;
            end
            r_raw.den_mag <= MAG_W'(r_d_mag);
            r_raw.den_neg <= r_d_neg;
        end
    end

    assign o_valid = r_s2_vld;
    assign o_raw   = r_raw;

endmodule

[src/rar_queue.sv]
// ----------------------------------------------------------------------------
// rar_queue: short request queue between front and back
// Two-entry register queue with valid/ready on both sides.
// ----------------------------------------------------------------------------
module rar_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rar_pkg::t_raw i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rar_pkg::t_raw o_data
);
    import rar_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);

    t_raw            r_mem [Q_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != (AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + AW'(1);
            if (pop)  r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

endmodule

[src/rar_back.sv]
// ----------------------------------------------------------------------------
// rar_back: gcd and reduction engine
// Euclid loop driven by a shared restoring divider, one quotient bit a
// cycle, then numerator and denominator divided by the signed gcd.
// ----------------------------------------------------------------------------
module rar_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rar_pkg::t_raw              i_raw,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [rar_pkg::OUT_W-1:0] o_res_num,
    output logic signed [rar_pkg::OUT_W-1:0] o_res_den,
    output logic                       o_zero_gcd
);
    import rar_pkg::*;

    t_state            r_state, n_state;
    t_raw              r_raw;
    logic [MAG_W-1:0]  r_x, r_y;
    logic              r_odd;
    logic [MAG_W-1:0]  r_g;
    logic              r_g_neg;
    // divider
    logic [MAG_W-1:0]  r_rem, r_quo, r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [OUT_W-1:0]  r_onum, r_oden;
    logic              r_ozero;

    logic [MAG_W:0]    trial;
    logic [MAG_W-1:0]  rem_sh;
    logic              fit;

    assign rem_sh = {r_rem[MAG_W-2:0], r_quo[MAG_W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, r_dvs};
    assign fit    = !trial[MAG_W] || r_rem[MAG_W-1];

    function automatic logic [OUT_W-1:0] sgn_out(input logic [MAG_W-1:0] q,
                                                  input logic neg);
        logic [OUT_W-1:0] t;
        t = OUT_W'(q);
        sgn_out = (neg && q != '0) ? (~t + OUT_W'(1)) : t;
    endfunction

    logic start_div;
    logic [MAG_W-1:0] div_a, div_b;

    // sequencer
    always_comb begin
        n_state   = r_state;
        start_div = 1'b0;
        div_a     = r_x;
        div_b     = r_y;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_GCD;
            ST_GCD: if (!r_busy) begin
                if (r_y == '0) begin
                    n_state = (r_x == '0) ? ST_OUT : ST_DIVN;
                    start_div = (r_x != '0);
                    div_a = r_raw.num_mag;
                    div_b = r_x;
                end else begin
                    start_div = 1'b1;
                end
            end
            ST_DIVN: if (!r_busy) begin
                n_state = ST_DIVD;
                start_div = 1'b1;
                div_a = r_raw.den_mag;
                div_b = r_g;
            end
            ST_DIVD: if (!r_busy) n_state = ST_OUT;
            ST_OUT:  if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (start_div) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CNT_W'(1)) begin
            r_busy <= 1'b0;
        end
        if (r_state == ST_IDLE && i_valid) begin
            r_raw <= i_raw;
            r_x   <= i_raw.num_mag;
            r_y   <= i_raw.den_mag;
            r_odd <= 1'b0;
        end
        if (start_div) begin
            r_rem <= '0;
            r_quo <= div_a;
            r_dvs <= div_b;
            r_cnt <= CNT_W'(MAG_W);
        end else if (r_busy) begin
            r_rem <= fit ? trial[MAG_W-1:0] : rem_sh;
            r_quo <= {r_quo[MAG_W-2:0], fit};
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1) && r_state == ST_GCD) begin
                r_x   <= r_y;
                r_y   <= fit ? trial[MAG_W-1:0] : rem_sh;
                r_odd <= !r_odd;
            end
            if (r_cnt == CNT_W'(1) && r_state == ST_DIVN)
                r_onum <= sgn_out({r_quo[MAG_W-2:0], fit}, r_raw.num_neg != r_g_neg);
            if (r_cnt == CNT_W'(1) && r_state == ST_DIVD)
                r_oden <= sgn_out({r_quo[MAG_W-2:0], fit}, r_raw.den_neg != r_g_neg);
        end
        if (r_state == ST_GCD && !r_busy && r_y == '0) begin
            r_g     <= r_x;
            r_g_neg <= (r_x != '0) && (r_odd ? r_raw.den_neg : r_raw.num_neg);
            r_ozero <= (r_x == '0);
            if (r_x == '0) begin
                r_onum <= '0;
                r_oden <= '0;
            end
        end
    end

    assign o_ready    = (r_state == ST_IDLE);
    assign o_valid    = (r_state == ST_OUT);
    assign o_res_num  = r_onum;
    assign o_res_den  = r_oden;
    assign o_zero_gcd = r_ozero;

endmodule

[src/rational_arith_reduce_unit.sv]
// ----------------------------------------------------------------------------
// rational_arith_reduce_unit: signed fraction arithmetic with gcd reduction
// The front forms the raw fraction, the queue holds it and the back runs the
// Euclid steps and the two reductions; it skips both when both raw parts are
// zero. The back takes one request per run and no new one until its result
// is taken; the one-bit-a-cycle divider is shared by the Euclid loop and the
// two reductions.
// Reset: synchronous active low, empties the pipeline, queue and sequencer.
// ----------------------------------------------------------------------------
module rational_arith_reduce_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_func,
    input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] i_b_den,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rar_pkg::OUT_W-1:0]  o_res_num,
    output logic signed [rar_pkg::OUT_W-1:0]  o_res_den,
    output logic                              o_zero_gcd
);
    import rar_pkg::*;

    logic f_vld, f_rdy, b_vld, b_rdy;
    t_raw f_raw, b_raw;

    rar_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_func, .i_a_num, .i_a_den, .i_b_num, .i_b_den,
        .o_valid(f_vld), .i_ready(f_rdy), .o_raw(f_raw)
    );

    rar_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_vld), .o_ready(f_rdy), .i_data(f_raw),
        .o_valid(b_vld), .i_ready(b_rdy), .o_data(b_raw)
    );

    rar_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(b_vld), .o_ready(b_rdy), .i_raw(b_raw),
        .o_valid, .i_ready, .o_res_num, .o_res_den, .o_zero_gcd
    );

endmodule
